// File: sv/mh2_pkg.sv
`default_nettype none

package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_K1,
        OP_K2,
        OP_HMIX,
        OP_TAIL,
        OP_FIN1
    } mh2_op_t;

    typedef struct packed {
        logic    load;
        logic    first;
        mh2_op_t op;
        logic    out_load;
    } mh2_cmd_t;

    // bytes at and above the count are dropped; counts above four act as a full word
    function automatic logic [31:0] word_mask(input logic [2:0] n);
        logic [31:0] m;
        if (n[2]) begin
            m = 32'hffffffff;
        end else begin
            unique case (n[1:0])
                2'd0: m = 32'h00000000;
                2'd1: m = 32'h000000ff;
                2'd2: m = 32'h0000ffff;
                2'd3: m = 32'h00ffffff;
                default: m = 32'h00000000;
            endcase
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: sv/mh2_datapath.sv
`default_nettype none

module mh2_datapath
    import mh2_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire mh2_cmd_t    cmd,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic [31:0] key_length,
    output logic      [31:0] hash_value
);

    logic [31:0] seed_reg, seed_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] out_reg, out_next;
    logic [31:0] mul_a;
    logic [31:0] product;

    assign product    = mul_a * MIX_MUL;
    assign hash_value = out_reg;

    always_comb begin
        seed_next = cfg_we ? cfg_wdata : seed_reg;
        h_next    = h_reg;
        k_next    = k_reg;
        out_next  = out_reg;
        mul_a     = k_reg;

        unique case (cmd.op)
            OP_NONE: begin
                mul_a = k_reg;
            end
            OP_K1: begin
                mul_a  = k_reg;
                k_next = product;
            end
            OP_K2: begin
                mul_a  = k_reg ^ (k_reg >> MIX_SHIFT);
                k_next = product;
            end
            OP_HMIX: begin
                mul_a  = h_reg;
                h_next = product ^ k_reg;
            end
            OP_TAIL: begin
                mul_a  = h_reg ^ k_reg;
                h_next = product;
            end
            OP_FIN1: begin
                mul_a  = h_reg ^ (h_reg >> FIN_SHIFT_A);
                h_next = product;
            end
            default: begin
                mul_a = k_reg;
            end
        endcase

        if (cmd.load) begin
            h_next = cmd.first ? (seed_reg ^ key_length) : h_reg;
            k_next = data_word & word_mask(byte_count);
        end

        if (cmd.out_load) begin
            out_next = h_reg ^ (h_reg >> FIN_SHIFT_B);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else begin
            seed_reg <= seed_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg   <= h_next;
        k_reg   <= k_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// File: sv/mh2_ctrl.sv
`default_nettype none

module mh2_ctrl
    import mh2_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_byte_count,
    input  wire logic       s_is_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output mh2_cmd_t        cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_K1   = 7'b0000010,
        ST_K2   = 7'b0000100,
        ST_HMIX = 7'b0001000,
        ST_TAIL = 7'b0010000,
        ST_FIN1 = 7'b0100000,
        ST_FIN2 = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   in_key_reg, in_key_next;
    logic   last_reg, last_next;
    logic   out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        in_key_next    = in_key_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '{load: 1'b0, first: 1'b0, op: OP_NONE, out_load: 1'b0};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load    = 1'b1;
                    cmd.first   = !in_key_reg;
                    last_next   = s_is_last;
                    in_key_next = !s_is_last;
                    if (s_byte_count[2]) begin
                        state_next = ST_K1;
                    end else if (s_byte_count != 3'd0) begin
                        state_next = ST_TAIL;
                    end else if (s_is_last) begin
                        state_next = ST_FIN1;
                    end
                end
            end
            ST_K1: begin
                cmd.op     = OP_K1;
                state_next = ST_K2;
            end
            ST_K2: begin
                cmd.op     = OP_K2;
                state_next = ST_HMIX;
            end
            ST_HMIX: begin
                cmd.op     = OP_HMIX;
                state_next = last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_TAIL: begin
                cmd.op     = OP_TAIL;
                state_next = last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1: begin
                cmd.op     = OP_FIN1;
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_key_reg    <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_key_reg    <= in_key_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/murmur2_hash_32_unit.sv
// Flow: a word is taken in IDLE; with 4 or more bytes it then passes K1, K2 and HMIX,
// with 1..3 bytes TAIL, and with 0 bytes no mix step (one shared 32x32 multiplier).
// A last word then runs FIN1 and FIN2; FIN2 waits while an earlier result is not taken,
// then loads the result and sets m_valid; the result register frees the input side.
// Reset: aresetn (synchronous, active low) clears the seed to 0, the controller and m_valid.
`default_nettype none

module murmur2_hash_32_unit
    import mh2_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_data_word,
    input  wire logic [2:0]  s_byte_count,
    input  wire logic        s_is_last,
    input  wire logic [31:0] s_key_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_hash_value
);

    mh2_cmd_t cmd;

    mh2_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_count (s_byte_count),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .cmd          (cmd)
    );

    mh2_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .data_word  (s_data_word),
        .byte_count (s_byte_count),
        .key_length (s_key_length),
        .hash_value (m_hash_value)
    );

endmodule

`default_nettype wire

// File: tb/sv/murmur2_hash_32_unit_tb.sv
`default_nettype none

module murmur2_hash_32_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] HASH_MUL    = 32'h5bd1e995;
    localparam int          BLK_SHIFT   = 24;
    localparam int          AV_SHIFT_A  = 13;
    localparam int          AV_SHIFT_B  = 15;
    localparam int          PHASE_WORDS = 230;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        last;
        logic [31:0] len;
        logic        lit_ok;
        logic [31:0] lit;
    } dir_row_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [31:0] cfg_wdata    = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word  = '0;
    logic [2:0]  s_byte_count = '0;
    logic        s_is_last    = 1'b0;
    logic [31:0] s_key_length = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [31:0] m_hash_value;

    logic [31:0] seed_shadow = '0;
    logic [31:0] hash_acc    = '0;
    logic        key_open    = 1'b0;
    logic [31:0] hash_exp_q [$];
    dir_row_t    dir_rows [$];

    int unsigned fail_count = 0;
    int unsigned words_sent = 0;
    int          burst_left = 0;
    logic [31:0] stall_pat  = '0;
    int          ready_hold = 0;

    murmur2_hash_32_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_is_last    (s_is_last),
        .s_key_length (s_key_length),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] block_mix(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] kk;
        kk = k * HASH_MUL;
        kk = kk ^ (kk >> BLK_SHIFT);
        kk = kk * HASH_MUL;
        return (h * HASH_MUL) ^ kk;
    endfunction

    function automatic logic [31:0] tail_mix(input logic [31:0] h, input logic [31:0] w,
                                             input logic [2:0] n);
        logic [31:0] keep;
        keep = (n == 3'd3) ? 32'h00ffffff : ((n == 3'd2) ? 32'h0000ffff : 32'h000000ff);
        return (h ^ (w & keep)) * HASH_MUL;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] x;
        x = h ^ (h >> AV_SHIFT_A);
        x = x * HASH_MUL;
        return x ^ (x >> AV_SHIFT_B);
    endfunction

    function automatic dir_row_t mk_row(input logic [31:0] w, input logic [2:0] c,
                                        input logic l, input logic [31:0] n,
                                        input logic lok, input logic [31:0] lv);
        dir_row_t r;
        r.word   = w;
        r.cnt    = c;
        r.last   = l;
        r.len    = n;
        r.lit_ok = lok;
        r.lit    = lv;
        return r;
    endfunction

    task automatic add_row(input dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic absorb_word(input logic [31:0] w, input logic [2:0] c, input logic last,
                               input logic [31:0] len, input logic lit_ok,
                               input logic [31:0] lit);
        logic [31:0] h;
        if (!key_open) begin
            hash_acc = seed_shadow ^ len;
            key_open = 1'b1;
        end
        h = hash_acc;
        if (c >= 3'd4) begin
            h = block_mix(h, w);
        end else if (c != 3'd0) begin
            h = tail_mix(h, w, c);
        end
        if (last) begin
            hash_exp_q.insert(hash_exp_q.size(), lit_ok ? lit : avalanche(h));
            hash_acc = '0;
            key_open = 1'b0;
        end else begin
            hash_acc = h;
        end
    endtask

    task automatic send_word(input logic [31:0] w, input logic [2:0] c, input logic last,
                             input logic [31:0] len, input logic lit_ok,
                             input logic [31:0] lit);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_data_word  <= w;
        s_byte_count <= c;
        s_is_last    <= last;
        s_key_length <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_word(w, c, last, len, lit_ok, lit);
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (hash_exp_q.size() != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic load_seed(input logic [31:0] v);
        drain();
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        seed_shadow = v;
        cfg_we <= 1'b0;
    endtask

    task automatic run_key();
        int   kind;
        int   nbytes;
        int   nfull;
        int   rem;
        int   n;
        int   i;
        logic fold;
        logic [31:0] len;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
            nfull  = nbytes / 4;
            rem    = nbytes % 4;
            fold   = (rem == 0) && (nfull > 0) && ($urandom_range(0, 1) == 1);
            for (i = 0; i < nfull; i++) begin
                send_word($urandom,
                          3'(($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : 4),
                          fold && (i == nfull - 1),
                          (i == 0) ? nbytes : $urandom, 1'b0, '0);
            end
            if (!fold) begin
                send_word($urandom, 3'(rem), 1'b1, (nfull == 0) ? nbytes : $urandom, 1'b0, '0);
            end
        end else begin
            // odd lengths, mid-key short words, stray last flags
            n   = $urandom_range(1, 8);
            len = (kind == 7) ? $urandom : $urandom_range(0, 40);
            for (i = 0; i < n; i++) begin
                send_word($urandom, 3'($urandom_range(0, 7)),
                          (i == n - 1) || (kind == 9 && $urandom_range(0, 2) == 0),
                          (i == 0) ? len : $urandom, 1'b0, '0);
            end
        end
        if ($urandom_range(0, 24) == 0) begin
            drain();
        end
    endtask

    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            ready_hold <= 64;
            stall_pat  <= ($urandom_range(0, 3) == 0) ? 32'hffffffff : ($urandom | 32'h1);
        end else begin
            ready_hold <= ready_hold - 1;
            stall_pat  <= {stall_pat[0], stall_pat[31:1]};
        end
        m_ready <= stall_pat[0];
    end

    always @(posedge aclk) begin : hash_check
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (hash_exp_q.size() == 0) begin
                $error("hash_value: expected none, actual %h", m_hash_value);
                fail_count++;
            end else begin
                want = hash_exp_q.pop_front();
                if (m_hash_value !== want) begin
                    $error("hash_value: expected %h, actual %h", want, m_hash_value);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("murmur2_hash_32_unit_tb: errors");
        $finish;
    end

    initial begin : stim
        logic [31:0] phase_seeds [$];
        int unsigned start_cnt;

        // seed is 0 from reset: empty keys finish to 0
        add_row(mk_row(32'hffffffff, 3'd0, 1'b1, 32'd0, 1'b1, 32'h0));
        add_row(mk_row(32'h00000000, 3'd4, 1'b1, 32'd4, 1'b0, '0));
        add_row(mk_row(32'hffffffff, 3'd4, 1'b1, 32'hffffffff, 1'b0, '0));
        add_row(mk_row(32'ha5a5a5a5, 3'd5, 1'b1, 32'd5, 1'b0, '0));
        add_row(mk_row(32'h5a5a5a5a, 3'd6, 1'b1, 32'd6, 1'b0, '0));
        add_row(mk_row(32'h12345678, 3'd7, 1'b1, 32'd7, 1'b0, '0));
        add_row(mk_row(32'hffffffff, 3'd1, 1'b1, 32'd1, 1'b0, '0));
        add_row(mk_row(32'hffffffff, 3'd2, 1'b1, 32'd2, 1'b0, '0));
        add_row(mk_row(32'hffffffff, 3'd3, 1'b1, 32'd3, 1'b0, '0));
        add_row(mk_row(32'h03020100, 3'd4, 1'b0, 32'd11, 1'b0, '0));
        add_row(mk_row(32'h07060504, 3'd4, 1'b0, 32'd0, 1'b0, '0));
        add_row(mk_row(32'hffcba987, 3'd3, 1'b1, 32'd0, 1'b0, '0));
        add_row(mk_row(32'hdeadbeef, 3'd2, 1'b0, 32'd9, 1'b0, '0));
        add_row(mk_row(32'hcafef00d, 3'd4, 1'b0, 32'd0, 1'b0, '0));
        add_row(mk_row(32'h01234567, 3'd3, 1'b0, 32'd0, 1'b0, '0));
        add_row(mk_row(32'h00000000, 3'd0, 1'b1, 32'd0, 1'b0, '0));
        add_row(mk_row(32'h89abcdef, 3'd4, 1'b1, 32'd1000, 1'b0, '0));
        add_row(mk_row(32'hffffffff, 3'd0, 1'b0, 32'd0, 1'b0, '0));
        add_row(mk_row(32'hffffffff, 3'd0, 1'b1, 32'd0, 1'b1, 32'h0));
        add_row(mk_row(32'hffffffff, 3'd4, 1'b0, 32'd8, 1'b0, '0));
        add_row(mk_row(32'hffffffff, 3'd4, 1'b1, 32'd8, 1'b0, '0));
        add_row(mk_row(32'h76543210, 3'd7, 1'b0, 32'd12, 1'b0, '0));
        add_row(mk_row(32'hfedcba98, 3'd1, 1'b1, 32'd0, 1'b0, '0));
        add_row(mk_row(32'h80000000, 3'd4, 1'b1, 32'h80000000, 1'b0, '0));

        phase_seeds.insert(phase_seeds.size(), 32'hffffffff);
        phase_seeds.insert(phase_seeds.size(), 32'h00000000);
        phase_seeds.insert(phase_seeds.size(), 32'h80000000);
        phase_seeds.insert(phase_seeds.size(), 32'h00000001);
        phase_seeds.insert(phase_seeds.size(), $urandom);
        phase_seeds.insert(phase_seeds.size(), $urandom);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].word, dir_rows[i].cnt, dir_rows[i].last,
                      dir_rows[i].len, dir_rows[i].lit_ok, dir_rows[i].lit);
        end

        foreach (phase_seeds[p]) begin
            load_seed(phase_seeds[p]);
            start_cnt = words_sent;
            while (words_sent - start_cnt < PHASE_WORDS) begin
                run_key();
            end
        end

        drain();
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("murmur2_hash_32_unit_tb: clean");
        end else begin
            $display("murmur2_hash_32_unit_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
